// ===== rtl/core/essm_pkg.sv =====
// Package with the shared types and constants of the engine-sound spool mapper.
package essm_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  localparam logic CFG_TOP_SPEED   = 1'b0;
  localparam logic CFG_MASTER_GAIN = 1'b1;

  localparam logic [15:0] TOP_SPEED_RST   = 16'd12800;
  localparam logic [15:0] MASTER_GAIN_RST = 16'd16384;
  localparam logic [15:0] TOP_MIN         = 16'd256;
  localparam logic [15:0] DT_MAX          = 16'd6553;
  localparam logic [14:0] ONE_Q14         = 15'd16384;

  localparam logic [15:0] K_TGT_BASE = 16'd2949;
  localparam logic [15:0] K_TGT_MUL  = 16'd13434;
  localparam logic [15:0] K_RATE_UP  = 16'd52428;
  localparam logic [15:0] K_RATE_DN  = 16'd29491;
  localparam logic [15:0] K_WP_BASE  = 16'd13926;
  localparam logic [15:0] K_WP_SN    = 16'd13107;
  localparam logic [15:0] K_WP_SP    = 16'd1966;
  localparam logic [15:0] K_WA_BASE  = 16'd3276;
  localparam logic [15:0] K_WA_SN    = 16'd7372;
  localparam logic [15:0] K_WB_BASE  = 16'd9830;
  localparam logic [15:0] K_WB_SP    = 16'd6553;
  localparam logic [15:0] K_TP_BASE  = 16'd11468;
  localparam logic [15:0] K_TP_SN    = 16'd9011;
  localparam logic [15:0] K_TP_SP    = 16'd1638;
  localparam logic [15:0] K_TA_BASE  = 16'd1638;
  localparam logic [15:0] K_TA_SN    = 16'd13926;
  localparam logic [15:0] K_TB_BASE  = 16'd7372;
  localparam logic [15:0] K_TB_SP    = 16'd9830;
  localparam logic [15:0] K_CAP      = 16'd18022;
  localparam logic [17:0] WP_LO = 18'd11468;
  localparam logic [17:0] WP_HI = 18'd31129;
  localparam logic [17:0] TP_LO = 18'd9830;
  localparam logic [17:0] TP_HI = 18'd26214;

  localparam int QUOT_BITS = 15;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_OUT  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  // Control toward the divider.
  typedef struct packed {
    logic        start;
    logic [14:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [14:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/core/essm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the speed ratio.
module essm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  essm_pkg::div_req_t req,
  output essm_pkg::div_rsp_t rsp
);
  import essm_pkg::*;

  // Quotient (speed<<14)/top < 16384 since speed < top; the 30-bit numerator
  // takes 30 steps, and the upper quotient bits always come out zero.
  logic [15:0] rem_r, rem_nxt;
  logic [29:0] num_r, num_nxt;
  logic [14:0] q_r, q_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;
  logic [16:0] shifted;

  always_comb begin
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, num_r[29]};
    trial    = shifted - {1'b0, dvs_r};
    if (req.start) begin
      rem_nxt  = '0;
      num_nxt  = {1'b0, req.dividend, 14'd0};
      dvs_nxt  = req.divisor;
      q_nxt    = '0;
      cnt_nxt  = 5'(QUOT_BITS + 15);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[28:0], 1'b0};
      if (!trial[16]) begin
        rem_nxt = trial[15:0];
        q_nxt   = {q_r[13:0], 1'b1};
      end else begin
        rem_nxt = shifted[15:0];
        q_nxt   = {q_r[13:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
endmodule

// ===== rtl/core/engine_sound_spool_mapper_top.sv =====
// Top level of the engine-sound spool mapper.
// A start beat while stopped clears the spool level and sets the block running,
// a stop beat clears the running flag, and a tick beat while running yields one
// result beat carrying whine and thrust pitch and volume. Start, stop, unused op
// codes and ticks while stopped give no result. A tick whose speed needs a real
// division passes through the bit-serial divider that forms the speed ratio,
// then takes 16 steps through a single shared 18x18 multiplier, one product per
// cycle, then clamping into the output register, and then holds the result beat
// until it is taken. A tick whose speed is not positive or reaches the top speed
// skips the divider. in_stall is high from the accepted tick until its result
// beat is taken. Configuration writes are taken at any time but must only be
// issued while the block is idle.
module engine_sound_spool_mapper_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_elapsed,
  input  logic signed [15:0] in_speed,
  input  logic signed [15:0] in_throttle_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_whine_pitch,
  output logic [15:0] out_whine_volume,
  output logic [14:0] out_thrust_pitch,
  output logic [16:0] out_thrust_volume,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import essm_pkg::*;

  state_t state_r, state_nxt;
  logic [15:0] top_speed_r, master_gain_r;
  logic [14:0] spool_r, spool_nxt;
  logic        running_r, running_nxt;

  // Latched, clamped operands of the tick in flight.
  logic [15:0] dt_r, dt_nxt;
  logic [14:0] thr_r, thr_nxt;
  logic [14:0] sn_r, sn_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [17:0] acc_r, acc_nxt;   // shared product register
  logic [15:0] target_r, target_nxt;
  logic [17:0] wp_r, wp_nxt, tp_r, tp_nxt;
  logic [17:0] wa_r, wa_nxt, wb_r, wb_nxt, ta_r, ta_nxt, tb_r, tb_nxt;
  logic [17:0] cap_r, cap_nxt;
  logic [17:0] wv_r, wv_nxt, tv_r, tv_nxt;
  logic        neg_r, neg_nxt;

  logic [14:0] o_wp_r, o_wp_nxt, o_tp_r, o_tp_nxt;
  logic [15:0] o_wv_r, o_wv_nxt;
  logic [16:0] o_tv_r, o_tv_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Shared multiplier: 18x18, result shifted down by 14 or 16.
  logic [17:0] mul_a, mul_b;
  logic [35:0] mul_p;
  logic [17:0] mq14;
  logic [17:0] mq16;
  assign mul_p = mul_a * mul_b;
  assign mq14  = mul_p[31:14];
  assign mq16  = mul_p[33:16];

  div_req_t dreq;
  div_rsp_t drsp;
  essm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic        in_fire;
  logic [15:0] top_eff;
  logic [15:0] spd_u;
  logic [15:0] spool_ext;
  logic [15:0] mag;
  logic [16:0] nsp;

  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign top_eff   = (top_speed_r < TOP_MIN) ? TOP_MIN : top_speed_r;
  assign spd_u     = in_speed;
  assign spool_ext = {1'b0, spool_r};
  assign mag       = neg_r ? (spool_ext - target_r) : (target_r - spool_ext);

  // Multiplier operand selection per step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      4'd0:  begin mul_a = 18'(K_TGT_MUL); mul_b = 18'(thr_r); end
      4'd1:  begin mul_a = 18'(dt_r);
               mul_b = 18'((target_r > spool_ext) ? K_RATE_UP : K_RATE_DN); end
      4'd2:  begin mul_a = 18'(mag); mul_b = acc_r; end
      4'd3:  begin mul_a = 18'(K_WP_SN); mul_b = 18'(sn_r); end
      4'd4:  begin mul_a = 18'(K_WP_SP); mul_b = 18'(spool_r); end
      4'd5:  begin mul_a = 18'(K_WA_SN); mul_b = 18'(sn_r); end
      4'd6:  begin mul_a = 18'(K_WB_SP); mul_b = 18'(spool_r); end
      4'd7:  begin mul_a = 18'(K_TP_SN); mul_b = 18'(sn_r); end
      4'd8:  begin mul_a = 18'(K_TP_SP); mul_b = 18'(spool_r); end
      4'd9:  begin mul_a = 18'(K_TA_SN); mul_b = 18'(sn_r); end
      4'd10: begin mul_a = 18'(K_TB_SP); mul_b = 18'(spool_r); end
      4'd11: begin mul_a = 18'(master_gain_r); mul_b = wa_r; end
      4'd12: begin mul_a = acc_r; mul_b = wb_r; end
      4'd13: begin mul_a = 18'(master_gain_r); mul_b = ta_r; end
      4'd14: begin mul_a = acc_r; mul_b = tb_r; end
      4'd15: begin mul_a = 18'(master_gain_r); mul_b = 18'(K_CAP); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    spool_nxt     = spool_r;
    running_nxt   = running_r;
    dt_nxt        = dt_r;
    thr_nxt       = thr_r;
    sn_nxt        = sn_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    target_nxt    = target_r;
    wp_nxt = wp_r; tp_nxt = tp_r; wa_nxt = wa_r; wb_nxt = wb_r;
    ta_nxt = ta_r; tb_nxt = tb_r; cap_nxt = cap_r; wv_nxt = wv_r; tv_nxt = tv_r;
    neg_nxt       = neg_r;
    o_wp_nxt = o_wp_r; o_tp_nxt = o_tp_r; o_wv_nxt = o_wv_r; o_tv_nxt = o_tv_r;
    out_valid_nxt = out_valid_r;
    dreq.start    = 1'b0;
    dreq.dividend = in_speed[14:0];
    dreq.divisor  = top_eff;
    nsp           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_START: begin
              if (!running_r) begin
                spool_nxt   = '0;
                running_nxt = 1'b1;
              end
            end
            OP_STOP: running_nxt = 1'b0;
            OP_TICK: begin
              if (running_r) begin
                dt_nxt   = (in_elapsed > DT_MAX) ? DT_MAX : in_elapsed;
                thr_nxt  = in_throttle_in[15] ? 15'd0 :
                           ((in_throttle_in >= 16'sd16384) ? ONE_Q14 :
                            in_throttle_in[14:0]);
                step_nxt = '0;
                if (in_speed[15] || in_speed == 16'sd0) begin
                  sn_nxt    = '0;
                  state_nxt = ST_MUL;
                end else if (spd_u >= top_eff) begin
                  sn_nxt    = ONE_Q14;
                  state_nxt = ST_MUL;
                end else begin
                  dreq.start = 1'b1;
                  state_nxt  = ST_DIV;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (drsp.done) begin
          sn_nxt    = drsp.quot;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        step_nxt = step_r + 4'd1;
        case (step_r)
          4'd0: target_nxt = K_TGT_BASE + mq14[15:0];
          4'd1: begin
            acc_nxt = (mq16 > 18'(ONE_Q14)) ? 18'(ONE_Q14) : mq16;
            neg_nxt = (target_r < spool_ext);
          end
          4'd2: begin
            // Magnitude times gain, truncated, applied with the sign.
            if (neg_r) begin
              nsp = (mq14 > 18'(spool_r)) ? 17'd0 : 17'(18'(spool_r) - mq14);
            end else begin
              nsp = 17'(18'(spool_r) + mq14);
              if (nsp > 17'(ONE_Q14)) nsp = 17'(ONE_Q14);
            end
            spool_nxt = nsp[14:0];
          end
          4'd3:  wp_nxt = 18'(K_WP_BASE) + mq14;
          4'd4:  wp_nxt = wp_r + mq14;
          4'd5:  wa_nxt = 18'(K_WA_BASE) + mq14;
          4'd6:  wb_nxt = 18'(K_WB_BASE) + mq14;
          4'd7:  tp_nxt = 18'(K_TP_BASE) + mq14;
          4'd8:  tp_nxt = tp_r + mq14;
          4'd9:  ta_nxt = 18'(K_TA_BASE) + mq14;
          4'd10: tb_nxt = 18'(K_TB_BASE) + mq14;
          4'd11: acc_nxt = mq14;
          4'd12: wv_nxt = mq14;
          4'd13: acc_nxt = mq14;
          4'd14: tv_nxt = mq14;
          4'd15: begin
            cap_nxt   = mq14;
            state_nxt = ST_OUT;
          end
          default: ;
        endcase
      end
      ST_OUT: begin
        o_wp_nxt = (wp_r < WP_LO) ? WP_LO[14:0] : ((wp_r > WP_HI) ? WP_HI[14:0] : wp_r[14:0]);
        o_tp_nxt = (tp_r < TP_LO) ? TP_LO[14:0] : ((tp_r > TP_HI) ? TP_HI[14:0] : tp_r[14:0]);
        o_wv_nxt = (wv_r > 18'(master_gain_r)) ? master_gain_r : wv_r[15:0];
        o_tv_nxt = (tv_r > cap_r) ? cap_r[16:0] : tv_r[16:0];
        out_valid_nxt = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      spool_r       <= '0;
      running_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      step_r        <= '0;
      top_speed_r   <= TOP_SPEED_RST;
      master_gain_r <= MASTER_GAIN_RST;
    end else begin
      state_r     <= state_nxt;
      spool_r     <= spool_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TOP_SPEED:   top_speed_r   <= cfg_data;
          CFG_MASTER_GAIN: master_gain_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    dt_r <= dt_nxt; thr_r <= thr_nxt; sn_r <= sn_nxt; acc_r <= acc_nxt;
    target_r <= target_nxt; neg_r <= neg_nxt;
    wp_r <= wp_nxt; tp_r <= tp_nxt; wa_r <= wa_nxt; wb_r <= wb_nxt;
    ta_r <= ta_nxt; tb_r <= tb_nxt; cap_r <= cap_nxt; wv_r <= wv_nxt; tv_r <= tv_nxt;
    o_wp_r <= o_wp_nxt; o_tp_r <= o_tp_nxt; o_wv_r <= o_wv_nxt; o_tv_r <= o_tv_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_whine_pitch   = o_wp_r;
  assign out_whine_volume  = o_wv_r;
  assign out_thrust_pitch  = o_tp_r;
  assign out_thrust_volume = o_tv_r;
endmodule

// ===== rtl/core/essm_checker.sv =====
// Port-level checker for the engine-sound spool mapper, with its bind.
module essm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_op,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_whine_volume,
  input logic [14:0] out_whine_pitch,
  input logic [14:0] out_thrust_pitch
);
  import essm_pkg::*;

  // A result is only ever pending while the input side is held off.
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result pending while input open");

  // Start and stop beats never produce a result.
  a_ctrl_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_op == OP_START || in_op == OP_STOP)) |=> !out_valid)
    else $error("control beat produced a result");

  // Pitches stay inside their clamp windows.
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_whine_pitch >= 15'd11468 && out_whine_pitch <= 15'd31129 &&
                   out_thrust_pitch >= 15'd9830 && out_thrust_pitch <= 15'd26214))
    else $error("pitch out of range");

  // A stalled result stays valid and its whine volume holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_whine_volume)))
    else $error("stalled result changed");
endmodule

bind engine_sound_spool_mapper_top essm_checker u_essm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
  .out_valid(out_valid), .out_stall(out_stall), .out_whine_volume(out_whine_volume),
  .out_whine_pitch(out_whine_pitch), .out_thrust_pitch(out_thrust_pitch)
);
